>>> sv/dwt_pkg.sv
// ----------------------------------------------------------------------------
// dwt_pkg
// Types and constants for the data watchpoint table: request and response
// layouts, command and status codes, flag bit positions and table sizing.
// ----------------------------------------------------------------------------
package dwt_pkg;

    localparam int NUM_ENTRIES = 8;
    localparam int ADDR_BITS   = 16;

    localparam int IDX_W = (NUM_ENTRIES > 1) ? $clog2(NUM_ENTRIES) : 1;
    localparam logic [IDX_W-1:0] IDX_LAST = IDX_W'(NUM_ENTRIES - 1);

    localparam logic [15:0] ADDR_MASK = 16'((33'd1 << ADDR_BITS) - 33'd1);

    // apb register map
    localparam int          PADDR_W          = 3;
    localparam logic [PADDR_W-1:0] REG_PROBE_ATTACHED = PADDR_W'(0);

    typedef enum logic [1:0] {
        CMD_INSERT    = 2'd0,
        CMD_REMOVE    = 2'd1,
        CMD_CPU_READ  = 2'd2,
        CMD_CPU_WRITE = 2'd3
    } cmd_t;

    localparam logic [1:0] STATUS_DONE    = 2'd0;
    localparam logic [1:0] STATUS_FULL    = 2'd1;
    localparam logic [1:0] STATUS_IGNORED = 2'd2;

    localparam int FLAG_READ   = 0;
    localparam int FLAG_WRITE  = 1;
    localparam int FLAG_BREAK  = 2;
    localparam int FLAG_SIGNAL = 3;

    typedef struct packed {
        logic [1:0]  cmd;
        logic [15:0] addr;
        logic [15:0] span_len;
        logic [3:0]  flag_bits;
        logic [7:0]  data_value;
    } req_t;

    typedef struct packed {
        logic [1:0]  status;
        logic        hit;
        logic        break_request;
        logic        signal_raise;
        logic        event_is_write;
        logic [15:0] hit_addr;
        logic [7:0]  hit_value;
    } rsp_t;

endpackage

>>> sv/data_watchpoint_table_core.sv
// ----------------------------------------------------------------------------
// data_watchpoint_table_core
// Watchpoint table keyed by start address, scanned one entry per cycle.
// ----------------------------------------------------------------------------
// Each request (insert, remove, cpu read or cpu write) is taken only while the
// table is idle and then walks all NUM_ENTRIES entries through one shared
// compare unit, one entry per cycle, followed by a finish state that updates
// the table and loads the response register once that register is free. When
// the probe is not attached the scan is skipped and the status is IGNORED. The
// response register lets the next request be taken while a response still
// waits on rsp_stall. Among matching entries the lowest start address wins.
module data_watchpoint_table_core (
    input  logic                          clk,
    input  logic                          rst_n,

    input  logic                          req_valid,
    output logic                          req_stall,
    input  dwt_pkg::req_t                 req_data,

    output logic                          rsp_valid,
    input  logic                          rsp_stall,
    output dwt_pkg::rsp_t                 rsp_data,

    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [dwt_pkg::PADDR_W-1:0]   paddr,
    input  logic [31:0]                   pwdata,
    output logic [31:0]                   prdata,
    output logic                          pready
);
    import dwt_pkg::*;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_FINISH
    } state_t;

    state_t            state_reg, state_next;
    logic [IDX_W-1:0]  idx_reg;
    req_t              req_reg;
    logic              ignored_reg;
    logic              probe_attached_reg;

    logic              found_reg;
    logic [IDX_W-1:0]  found_idx_reg;
    logic [3:0]        found_flags_reg;
    logic              free_reg;
    logic [IDX_W-1:0]  free_idx_reg;
    logic              best_reg;
    logic [15:0]       best_start_reg;
    logic [3:0]        best_flags_reg;

    rsp_t              rsp_reg;
    logic              rsp_valid_reg;

    logic [NUM_ENTRIES-1:0] entry_valid_reg;
    logic [15:0]       entry_start_mem  [NUM_ENTRIES];
    logic [15:0]       entry_length_mem [NUM_ENTRIES];
    logic [3:0]        entry_flags_mem  [NUM_ENTRIES];

    logic              req_take;
    logic              rsp_free;
    logic              commit;
    logic              cfg_write;
    req_t              req_masked;

    logic              cur_valid;
    logic [15:0]       cur_start;
    logic [15:0]       cur_length;
    logic [3:0]        cur_flags;
    logic              is_access;
    logic              need_bit;
    logic [16:0]       range_end;
    logic              in_range;
    logic              access_match;
    logic              start_match;

    logic [3:0]        merged_flags;
    logic [3:0]        cleared_flags;
    rsp_t              rsp_next;

    assign req_stall = (state_reg != ST_IDLE);
    assign req_take  = req_valid && !req_stall;
    assign rsp_free  = !rsp_valid_reg || !rsp_stall;
    assign commit    = (state_reg == ST_FINISH) && rsp_free && !ignored_reg;

    assign rsp_valid = rsp_valid_reg;
    assign rsp_data  = rsp_reg;

    // configuration port
    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready;
    assign prdata    = (paddr == REG_PROBE_ATTACHED) ? {31'd0, probe_attached_reg} : 32'd0;

    always_comb
    begin
        req_masked      = req_data;
        req_masked.addr = req_data.addr & ADDR_MASK;
    end

    // shared compare unit on the entry under the scan index
    assign cur_valid  = entry_valid_reg[idx_reg];
    assign cur_start  = entry_start_mem[idx_reg];
    assign cur_length = entry_length_mem[idx_reg];
    assign cur_flags  = entry_flags_mem[idx_reg];

    assign is_access   = (req_reg.cmd == CMD_CPU_READ) || (req_reg.cmd == CMD_CPU_WRITE);
    assign need_bit    = (req_reg.cmd == CMD_CPU_WRITE) ? cur_flags[FLAG_WRITE]
                                                        : cur_flags[FLAG_READ];
    assign range_end   = {1'b0, cur_start} + {1'b0, cur_length};
    assign in_range    = (req_reg.addr >= cur_start) && ({1'b0, req_reg.addr} < range_end);
    assign access_match = cur_valid && is_access && need_bit && in_range;
    assign start_match  = cur_valid && (cur_start == req_reg.addr);

    assign merged_flags  = found_flags_reg | req_reg.flag_bits;
    assign cleared_flags = found_flags_reg & ~req_reg.flag_bits;

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (req_take)
                    state_next = probe_attached_reg ? ST_SCAN : ST_FINISH;
            end
            ST_SCAN:
            begin
                if (idx_reg == IDX_LAST)
                    state_next = ST_FINISH;
            end
            ST_FINISH:
            begin
                if (rsp_free)
                    state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        rsp_next = '0;
        if (ignored_reg)
        begin
            rsp_next.status = STATUS_IGNORED;
        end
        else if (req_reg.cmd == CMD_INSERT)
        begin
            if (!found_reg && !free_reg)
                rsp_next.status = STATUS_FULL;
        end
        else if (is_access && best_reg)
        begin
            rsp_next.hit            = 1'b1;
            rsp_next.break_request  = best_flags_reg[FLAG_BREAK];
            rsp_next.signal_raise   = best_flags_reg[FLAG_SIGNAL];
            rsp_next.event_is_write = (req_reg.cmd == CMD_CPU_WRITE);
            rsp_next.hit_addr       = req_reg.addr;
            rsp_next.hit_value      = req_reg.data_value;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg          <= ST_IDLE;
            idx_reg            <= '0;
            ignored_reg        <= 1'b0;
            probe_attached_reg <= 1'b1;
            found_reg          <= 1'b0;
            free_reg           <= 1'b0;
            best_reg           <= 1'b0;
            rsp_valid_reg      <= 1'b0;
            entry_valid_reg    <= '0;
        end
        else
        begin
            state_reg <= state_next;

            if (cfg_write && (paddr == REG_PROBE_ATTACHED))
                probe_attached_reg <= pwdata[0];

            // a new response may replace one taken at the same edge
            if ((state_reg == ST_FINISH) && rsp_free)
                rsp_valid_reg <= 1'b1;
            else if (rsp_valid_reg && !rsp_stall)
                rsp_valid_reg <= 1'b0;

            unique case (state_reg)
                ST_IDLE:
                begin
                    if (req_take)
                    begin
                        idx_reg       <= '0;
                        ignored_reg   <= !probe_attached_reg;
                        found_reg     <= 1'b0;
                        free_reg      <= 1'b0;
                        best_reg      <= 1'b0;
                    end
                end
                ST_SCAN:
                begin
                    if (idx_reg != IDX_LAST)
                        idx_reg <= idx_reg + IDX_W'(1);
                    if (start_match && !found_reg)
                        found_reg <= 1'b1;
                    if (!cur_valid && !free_reg)
                        free_reg <= 1'b1;
                    if (access_match && (!best_reg || (cur_start < best_start_reg)))
                        best_reg <= 1'b1;
                end
                ST_FINISH:
                begin
                    if (commit)
                    begin
                        if (req_reg.cmd == CMD_INSERT)
                        begin
                            if (!found_reg && free_reg)
                                entry_valid_reg[free_idx_reg] <= 1'b1;
                        end
                        else if (req_reg.cmd == CMD_REMOVE)
                        begin
                            if (found_reg && !cleared_flags[FLAG_READ]
                                && !cleared_flags[FLAG_WRITE])
                                entry_valid_reg[found_idx_reg] <= 1'b0;
                        end
                    end
                end
                default:
                begin
                    idx_reg <= '0;
                end
            endcase
        end
    end

    // payload registers, no reset
    always_ff @(posedge clk)
    begin
        if (req_take)
            req_reg <= req_masked;

        if (state_reg == ST_SCAN)
        begin
            if (start_match && !found_reg)
            begin
                found_idx_reg   <= idx_reg;
                found_flags_reg <= cur_flags;
            end
            if (!cur_valid && !free_reg)
                free_idx_reg <= idx_reg;
            if (access_match && (!best_reg || (cur_start < best_start_reg)))
            begin
                best_start_reg <= cur_start;
                best_flags_reg <= cur_flags;
            end
        end

        if ((state_reg == ST_FINISH) && rsp_free)
            rsp_reg <= rsp_next;

        if (commit)
        begin
            if (req_reg.cmd == CMD_INSERT)
            begin
                if (found_reg)
                begin
                    entry_flags_mem[found_idx_reg] <= merged_flags;
                end
                else if (free_reg)
                begin
                    entry_start_mem[free_idx_reg]  <= req_reg.addr;
                    entry_length_mem[free_idx_reg] <= req_reg.span_len;
                    entry_flags_mem[free_idx_reg]  <= req_reg.flag_bits;
                end
            end
            else if ((req_reg.cmd == CMD_REMOVE) && found_reg)
            begin
                entry_flags_mem[found_idx_reg] <= cleared_flags;
            end
        end
    end

endmodule
